>>> hdl/frame_rate_pacer_defines.svh
// assertion macros for the frame pacer checker
// expects clk and rst_n in the scope of each use
`ifndef FRAME_RATE_PACER_DEFINES_SVH
`define FRAME_RATE_PACER_DEFINES_SVH

// same-cycle implication, off while in reset
`define FRP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, off while in reset
`define FRP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// what must hold in the cycle after a reset edge
`define FRP_ASSERT_RST(lbl, cons, msg) \
  lbl: assert property (@(posedge clk) !rst_n |=> (cons)) else $error(msg);

`endif

>>> hdl/frp_pkg.sv
// frame pacer package: command codes, queue item, sequencer states, field layout
// no dependencies
`timescale 1ns / 1ps

package frp_pkg;

  // command codes carried in in_tuser
  typedef enum logic [1:0] {
    CMD_WAIT    = 2'd0,
    CMD_RENDER  = 2'd1,
    CMD_PRESENT = 2'd2,
    CMD_RESTART = 2'd3
  } cmd_t;

  // field widths
  localparam int unsigned TS_W     = 63;
  localparam int unsigned FREQ_W   = 32;
  localparam int unsigned FPS_W    = 10;
  localparam int unsigned MS_W     = 16;
  localparam int unsigned RATE_W   = 32;
  localparam int unsigned FCNT_W   = 32;
  localparam int unsigned PROD_W   = FCNT_W + FREQ_W;
  localparam int unsigned FRAC_W   = 8;
  localparam int unsigned MS_SCL_W = 10;

  // register reset values and limits
  localparam logic [FREQ_W-1:0] FREQ_RESET = 32'd10000000;
  localparam logic [FPS_W-1:0]  FPS_CLAMP  = 10'd1000;
  localparam int unsigned RESYNC_FRAMES = 8;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_TIMER_FREQ = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_FPS    = 1'b1;

  // input channel layout
  localparam int unsigned IN_DATA_W   = 64;
  localparam int unsigned IN_USER_W   = 2;
  localparam int unsigned IN_VSYNC_BIT = 63;

  // result channel layout
  localparam int unsigned OUT_OK_BIT   = 0;
  localparam int unsigned OUT_MS_LSB   = 1;
  localparam int unsigned OUT_SY_BIT   = 17;
  localparam int unsigned OUT_UPD_BIT  = 18;
  localparam int unsigned OUT_RATE_LSB = 19;
  localparam int unsigned OUT_DATA_W   = 56;

  // front queue depth, power of two
  localparam int unsigned QUEUE_DEPTH = 2;

  // one decoded input transaction
  typedef struct packed {
    cmd_t            cmd;
    logic [TS_W-1:0] ts;
    logic            vsync;
  } item_t;

  // back-end sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_P_START,
    ST_P_WAIT,
    ST_W_PREP,
    ST_W_START,
    ST_W_DIV,
    ST_F_ELAP,
    ST_F_CHK,
    ST_F_MUL,
    ST_F_START,
    ST_F_DIV,
    ST_C_ADV,
    ST_C_LIM,
    ST_C_FIX,
    ST_EMIT
  } state_t;

endpackage

>>> hdl/frame_rate_pacer.sv
// Frame pacer. One result transaction per input transaction, in order.
// Render queries and window restarts go straight to the result; a presented frame steps the
// window and deadline, with a rate division when the one-second window closes; a wait query
// divides when a deadline lies ahead. NUM_W = max(TIME_BITS + 10, 72), the bit-serial shared divider's width.
// One transaction is worked at a time; a 2-entry queue keeps accepting meanwhile.
// Sync active-low reset; a period update after a config write holds cfg_ready low.
`timescale 1ns / 1ps

module frame_rate_pacer #(
  parameter int unsigned TIME_BITS = 64
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [frp_pkg::IN_DATA_W-1:0]   in_tdata,   // timestamp[62:0], vsync[63]
  input  logic [frp_pkg::IN_USER_W-1:0]   in_tuser,   // cmd[1:0]
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // render_ok[0], wait_ms[16:1], short_yield[17], fps_updated[18], fps_x256[50:19]
  output logic [frp_pkg::OUT_DATA_W-1:0]  out_tdata,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [frp_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [frp_pkg::FREQ_W-1:0]      cfg_data
);

  localparam int unsigned RATE_NUM_W = frp_pkg::PROD_W + frp_pkg::FRAC_W;
  localparam int unsigned MS_NUM_W   = TIME_BITS + frp_pkg::MS_SCL_W;
  localparam int unsigned NUM_W      = (MS_NUM_W > RATE_NUM_W) ? MS_NUM_W : RATE_NUM_W;

  frp_pkg::item_t         q_item;
  logic                   q_valid;
  logic                   q_pop;
  logic                   div_start;
  logic [NUM_W-1:0]       div_dividend;
  logic [TIME_BITS-1:0]   div_divisor;
  logic                   div_done;
  logic [NUM_W-1:0]       div_quot;

  // accept and decode
  frp_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop)
  );

  // shared divider for period, milliseconds and rate
  frp_div #(
    .NUM_W (NUM_W),
    .DEN_W (TIME_BITS)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quot)
  );

  // command execution and results
  frp_back #(
    .TIME_BITS (TIME_BITS),
    .NUM_W     (NUM_W)
  ) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .q_valid      (q_valid),
    .q_item       (q_item),
    .q_pop        (q_pop),
    .div_start    (div_start),
    .div_dividend (div_dividend),
    .div_divisor  (div_divisor),
    .div_done     (div_done),
    .div_quot     (div_quot),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata)
  );

endmodule

>>> hdl/frp_front.sv
// frame pacer front end: accepts input transactions, decodes them, queues them
// depends on frp_pkg
`timescale 1ns / 1ps

module frp_front (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [frp_pkg::IN_DATA_W-1:0]  in_tdata,   // timestamp[62:0], vsync[63]
  input  logic [frp_pkg::IN_USER_W-1:0]  in_tuser,   // cmd[1:0]
  output logic                           q_valid,
  output frp_pkg::item_t                 q_item,
  input  logic                           q_pop
);

  localparam int unsigned QD     = frp_pkg::QUEUE_DEPTH;
  localparam int unsigned PTR_W  = (QD > 1) ? $clog2(QD) : 1;
  localparam int unsigned FILL_W = $clog2(QD + 1);

  frp_pkg::item_t    slot_r [QD];
  logic [PTR_W-1:0]  wr_ptr_r;
  logic [PTR_W-1:0]  rd_ptr_r;
  logic [FILL_W-1:0] fill_r;
  frp_pkg::item_t    item_in;
  logic              push;
  logic              pop;

  // decode the incoming transaction
  always_comb begin
    item_in.cmd   = frp_pkg::cmd_t'(in_tuser);
    item_in.ts    = in_tdata[frp_pkg::TS_W-1:0];
    item_in.vsync = in_tdata[frp_pkg::IN_VSYNC_BIT];
  end

  assign in_tready = (fill_r != FILL_W'(QD));
  assign q_valid   = (fill_r != '0);
  assign q_item    = slot_r[rd_ptr_r];
  assign push      = in_tvalid && in_tready;
  assign pop       = q_pop && q_valid;

  // queue pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + PTR_W'(1);
      if (pop) rd_ptr_r <= rd_ptr_r + PTR_W'(1);
      if (push && !pop) begin
        fill_r <= fill_r + FILL_W'(1);
      end else if (pop && !push) begin
        fill_r <= fill_r - FILL_W'(1);
      end
    end
  end

  // queue storage
  always_ff @(posedge clk) begin
    if (push) slot_r[wr_ptr_r] <= item_in;
  end

endmodule

>>> hdl/frp_div.sv
// frame pacer shared divider: restoring, one quotient bit per cycle
// no dependencies
`timescale 1ns / 1ps

module frp_div #(
  parameter int unsigned NUM_W = 72,
  parameter int unsigned DEN_W = 64
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] dividend,
  input  logic [DEN_W-1:0] divisor,
  output logic             done,
  output logic [NUM_W-1:0] quotient
);

  localparam int unsigned STEP_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0]  quo_r;
  logic [DEN_W-1:0]  rem_r;
  logic [DEN_W-1:0]  den_r;
  logic [STEP_W-1:0] step_r;
  logic              busy_r;
  logic              done_r;
  logic [DEN_W:0]    trial;
  logic [DEN_W:0]    diff;
  logic              fits;

  // one trial subtraction per cycle
  always_comb begin
    trial = {rem_r, quo_r[NUM_W-1]};
    diff  = trial - {1'b0, den_r};
    fits  = (trial >= {1'b0, den_r});
  end

  // iteration control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= STEP_W'(NUM_W);
      end else if (busy_r) begin
        step_r <= step_r - STEP_W'(1);
        if (step_r == STEP_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // remainder and quotient shift
  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      den_r <= divisor;
    end else if (busy_r) begin
      rem_r <= fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      quo_r <= {quo_r[NUM_W-2:0], fits};
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

>>> hdl/frp_back.sv
// frame pacer back end: register file, pacing state, command sequencer, result register
// depends on frp_pkg; drives the shared frp_div unit
`timescale 1ns / 1ps

module frp_back #(
  parameter int unsigned TIME_BITS = 64,
  parameter int unsigned NUM_W     = 72
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [frp_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [frp_pkg::FREQ_W-1:0]      cfg_data,
  input  logic                            q_valid,
  input  frp_pkg::item_t                  q_item,
  output logic                            q_pop,
  output logic                            div_start,
  output logic [NUM_W-1:0]                div_dividend,
  output logic [TIME_BITS-1:0]            div_divisor,
  input  logic                            div_done,
  input  logic [NUM_W-1:0]                div_quot,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [frp_pkg::OUT_DATA_W-1:0]  out_tdata
);

  localparam int unsigned TB     = TIME_BITS;
  localparam int unsigned SPAN_W = frp_pkg::FREQ_W + $clog2(frp_pkg::RESYNC_FRAMES + 1);
  localparam int unsigned SUM_W  = ((TB > SPAN_W) ? TB : SPAN_W) + 1;
  localparam logic [TB-1:0] TMAX = {TB{1'b1}};

  // saturating add at the time width
  function automatic logic [TB-1:0] sat_add(input logic [TB-1:0] a,
                                            input logic [SPAN_W-1:0] b);
    logic [SUM_W-1:0] s;
    s = SUM_W'(a) + SUM_W'(b);
    if (s > SUM_W'(TMAX)) return TMAX;
    return s[TB-1:0];
  endfunction

  frp_pkg::state_t state_r, state_nxt;

  // configuration and pacing state
  logic [frp_pkg::FREQ_W-1:0] timer_freq_r;
  logic [frp_pkg::FPS_W-1:0]  max_fps_r;
  logic [frp_pkg::FREQ_W-1:0] period_r;
  logic [TB-1:0]              deadline_r;
  logic [TB-1:0]              win_start_r;
  logic [frp_pkg::FCNT_W-1:0] frame_cnt_r;
  logic [frp_pkg::RATE_W-1:0] rate_r;

  // per-transaction working registers
  logic [TB-1:0]              now_r;
  logic                       vsync_r;
  logic [TB-1:0]              work_r;
  logic                       borrow_r;
  logic [frp_pkg::PROD_W-1:0] prod_r;
  logic [TB-1:0]              dl_next_r;
  logic [TB-1:0]              limit_r;
  logic                       render_ok_r;
  logic [frp_pkg::MS_W-1:0]   wait_ms_r;
  logic                       short_yield_r;
  logic                       fps_upd_r;
  logic                       out_valid_r;
  logic [frp_pkg::OUT_DATA_W-1:0] out_data_r;

  // combinational helpers
  logic [frp_pkg::FPS_W-1:0]  cfg_fps_v;
  logic                       cfg_is_freq;
  logic                       cfg_is_fps;
  logic                       cfg_changed;
  logic [frp_pkg::FPS_W-1:0]  cfg_new_fps;
  logic                       cfg_need_div;
  logic [63:0]                ts_q64;
  logic [TB-1:0]              now_q;
  logic                       cap_q;
  logic                       render_q;
  logic                       capping;
  logic [TB-1:0]              dl_eff;
  logic                       wait_go;
  logic                       win_close;
  logic [SPAN_W-1:0]          span;
  logic [TB:0]                elapsed;
  logic [frp_pkg::MS_W-1:0]   ms_sat;
  logic [frp_pkg::RATE_W-1:0] rate_sat;
  logic [NUM_W-1:0]           rem_x1000;
  logic                       load_ok;
  logic [frp_pkg::OUT_DATA_W-1:0] res_word;

  // config write decode, max_fps clamps at the cap
  always_comb begin
    cfg_fps_v   = (cfg_data[frp_pkg::FPS_W-1:0] > frp_pkg::FPS_CLAMP) ?
                  frp_pkg::FPS_CLAMP : cfg_data[frp_pkg::FPS_W-1:0];
    cfg_is_freq = (cfg_index == frp_pkg::REG_TIMER_FREQ);
    cfg_is_fps  = (cfg_index == frp_pkg::REG_MAX_FPS);
    cfg_changed = cfg_is_fps  ? (cfg_fps_v != max_fps_r) :
                  cfg_is_freq ? (cfg_data != timer_freq_r) : 1'b0;
    cfg_new_fps = cfg_is_fps ? cfg_fps_v : max_fps_r;
    cfg_need_div = cfg_changed && (cfg_new_fps != '0);
  end

  // head-of-queue view and render decision
  always_comb begin
    ts_q64   = {1'b0, q_item.ts};
    now_q    = ts_q64[TB-1:0];
    cap_q    = !q_item.vsync && (period_r != '0);
    render_q = !(cap_q && (deadline_r != '0) && (now_q < deadline_r));
  end

  // working transaction view
  always_comb begin
    capping   = !vsync_r && (period_r != '0);
    dl_eff    = (deadline_r == '0) ? now_r : deadline_r;
    wait_go   = capping && (timer_freq_r != '0) && (dl_eff > now_r);
    elapsed   = {1'b0, now_r} - {1'b0, win_start_r};
    win_close = !borrow_r && (timer_freq_r != '0) && (work_r >= TB'(timer_freq_r));
    span      = SPAN_W'(period_r) * SPAN_W'(frp_pkg::RESYNC_FRAMES);
    rem_x1000 = (NUM_W'(work_r) << 10) - (NUM_W'(work_r) << 5) + (NUM_W'(work_r) << 3);
    ms_sat    = (div_quot > NUM_W'({frp_pkg::MS_W{1'b1}})) ?
                {frp_pkg::MS_W{1'b1}} : div_quot[frp_pkg::MS_W-1:0];
    rate_sat  = (div_quot > NUM_W'({frp_pkg::RATE_W{1'b1}})) ?
                {frp_pkg::RATE_W{1'b1}} : div_quot[frp_pkg::RATE_W-1:0];
  end

  // result word, fields packed from bit 0 up
  always_comb begin
    res_word = '0;
    res_word[frp_pkg::OUT_OK_BIT] = render_ok_r;
    res_word[frp_pkg::OUT_MS_LSB +: frp_pkg::MS_W] = wait_ms_r;
    res_word[frp_pkg::OUT_SY_BIT] = short_yield_r;
    res_word[frp_pkg::OUT_UPD_BIT] = fps_upd_r;
    res_word[frp_pkg::OUT_RATE_LSB +: frp_pkg::RATE_W] = rate_r;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      frp_pkg::ST_IDLE: begin
        if (cfg_valid) begin
          state_nxt = cfg_need_div ? frp_pkg::ST_P_START : frp_pkg::ST_IDLE;
        end else if (q_valid) begin
          unique case (q_item.cmd)
            frp_pkg::CMD_WAIT:    state_nxt = frp_pkg::ST_W_PREP;
            frp_pkg::CMD_RENDER:  state_nxt = frp_pkg::ST_EMIT;
            frp_pkg::CMD_PRESENT: state_nxt = frp_pkg::ST_F_ELAP;
            frp_pkg::CMD_RESTART: state_nxt = frp_pkg::ST_EMIT;
            default:              state_nxt = frp_pkg::ST_EMIT;
          endcase
        end
      end
      frp_pkg::ST_P_START: state_nxt = frp_pkg::ST_P_WAIT;
      frp_pkg::ST_P_WAIT:  if (div_done) state_nxt = frp_pkg::ST_IDLE;
      frp_pkg::ST_W_PREP:  state_nxt = wait_go ? frp_pkg::ST_W_START : frp_pkg::ST_EMIT;
      frp_pkg::ST_W_START: state_nxt = frp_pkg::ST_W_DIV;
      frp_pkg::ST_W_DIV:   if (div_done) state_nxt = frp_pkg::ST_EMIT;
      frp_pkg::ST_F_ELAP:  state_nxt = frp_pkg::ST_F_CHK;
      frp_pkg::ST_F_CHK:   state_nxt = win_close ? frp_pkg::ST_F_MUL : frp_pkg::ST_C_ADV;
      frp_pkg::ST_F_MUL:   state_nxt = frp_pkg::ST_F_START;
      frp_pkg::ST_F_START: state_nxt = frp_pkg::ST_F_DIV;
      frp_pkg::ST_F_DIV:   if (div_done) state_nxt = frp_pkg::ST_C_ADV;
      frp_pkg::ST_C_ADV:   state_nxt = capping ? frp_pkg::ST_C_LIM : frp_pkg::ST_EMIT;
      frp_pkg::ST_C_LIM:   state_nxt = frp_pkg::ST_C_FIX;
      frp_pkg::ST_C_FIX:   state_nxt = frp_pkg::ST_EMIT;
      frp_pkg::ST_EMIT:    if (load_ok) state_nxt = frp_pkg::ST_IDLE;
      default:             state_nxt = frp_pkg::ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    cfg_ready    = (state_r == frp_pkg::ST_IDLE);
    q_pop        = (state_r == frp_pkg::ST_IDLE) && !cfg_valid && q_valid;
    load_ok      = !out_valid_r || out_tready;
    div_start    = 1'b0;
    div_dividend = '0;
    div_divisor  = '0;
    unique case (state_r)
      frp_pkg::ST_P_START: begin
        div_start    = 1'b1;
        div_dividend = NUM_W'(timer_freq_r);
        div_divisor  = TB'(max_fps_r);
      end
      frp_pkg::ST_W_START: begin
        div_start    = 1'b1;
        div_dividend = rem_x1000;
        div_divisor  = TB'(timer_freq_r);
      end
      frp_pkg::ST_F_START: begin
        div_start    = 1'b1;
        div_dividend = NUM_W'({prod_r, {frp_pkg::FRAC_W{1'b0}}});
        div_divisor  = work_r;
      end
      default: begin
        div_start    = 1'b0;
      end
    endcase
  end

  // control, configuration and pacing state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= frp_pkg::ST_IDLE;
      timer_freq_r <= frp_pkg::FREQ_RESET;
      max_fps_r    <= '0;
      period_r     <= '0;
      deadline_r   <= '0;
      win_start_r  <= '0;
      frame_cnt_r  <= '0;
      rate_r       <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_tready) out_valid_r <= 1'b0;
      unique case (state_r)
        frp_pkg::ST_IDLE: begin
          if (cfg_valid) begin
            // a changed register clears the schedule
            if (cfg_changed) begin
              deadline_r <= '0;
              if (cfg_is_fps) max_fps_r <= cfg_fps_v;
              else timer_freq_r <= cfg_data;
              if (cfg_new_fps == '0) period_r <= '0;
            end
          end else if (q_valid) begin
            if (q_item.cmd == frp_pkg::CMD_PRESENT) begin
              if (frame_cnt_r != '1) frame_cnt_r <= frame_cnt_r + frp_pkg::FCNT_W'(1);
            end else if (q_item.cmd == frp_pkg::CMD_RESTART) begin
              win_start_r <= now_q;
              frame_cnt_r <= '0;
            end
          end
        end
        frp_pkg::ST_P_WAIT: begin
          if (div_done) period_r <= div_quot[frp_pkg::FREQ_W-1:0];
        end
        frp_pkg::ST_W_PREP: begin
          if (capping && (timer_freq_r != '0)) deadline_r <= dl_eff;
        end
        frp_pkg::ST_F_DIV: begin
          if (div_done) begin
            rate_r      <= rate_sat;
            frame_cnt_r <= '0;
            win_start_r <= now_r;
          end
        end
        frp_pkg::ST_C_FIX: begin
          // resync when too far behind the schedule
          deadline_r <= (now_r > limit_r) ? sat_add(now_r, SPAN_W'(period_r)) : dl_next_r;
        end
        frp_pkg::ST_EMIT: begin
          if (load_ok) out_valid_r <= 1'b1;
        end
        default: begin
          out_valid_r <= out_valid_r && !out_tready;
        end
      endcase
    end
  end

  // per-transaction working registers and result fields
  always_ff @(posedge clk) begin
    unique case (state_r)
      frp_pkg::ST_IDLE: begin
        if (!cfg_valid && q_valid) begin
          now_r         <= now_q;
          vsync_r       <= q_item.vsync;
          render_ok_r   <= (q_item.cmd == frp_pkg::CMD_RENDER) ? render_q : 1'b0;
          wait_ms_r     <= '0;
          short_yield_r <= 1'b0;
          fps_upd_r     <= 1'b0;
        end
      end
      frp_pkg::ST_W_PREP: begin
        work_r <= dl_eff - now_r;
      end
      frp_pkg::ST_W_DIV: begin
        if (div_done) begin
          wait_ms_r     <= ms_sat;
          short_yield_r <= (ms_sat == '0);
        end
      end
      frp_pkg::ST_F_ELAP: begin
        borrow_r <= elapsed[TB];
        work_r   <= elapsed[TB-1:0];
      end
      frp_pkg::ST_F_MUL: begin
        prod_r <= frp_pkg::PROD_W'(frame_cnt_r) * frp_pkg::PROD_W'(timer_freq_r);
      end
      frp_pkg::ST_F_DIV: begin
        if (div_done) fps_upd_r <= 1'b1;
      end
      frp_pkg::ST_C_ADV: begin
        dl_next_r <= sat_add(dl_eff, SPAN_W'(period_r));
      end
      frp_pkg::ST_C_LIM: begin
        limit_r <= sat_add(dl_next_r, span);
      end
      frp_pkg::ST_EMIT: begin
        if (load_ok) out_data_r <= res_word;
      end
      default: begin
        out_data_r <= out_data_r;
      end
    endcase
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

>>> hdl/frp_checker.sv
// frame pacer port checker and its bind to the top level
// depends on frp_pkg and frame_rate_pacer_defines.svh
`timescale 1ns / 1ps
`include "frame_rate_pacer_defines.svh"

module frp_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           out_tvalid,
  input logic                           out_tready,
  input logic [frp_pkg::OUT_DATA_W-1:0] out_tdata
);

  // result register empties on reset
  `FRP_ASSERT_RST(a_rst_out_empty, !out_tvalid, "result valid after reset")

  // a stalled result stays offered
  `FRP_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid, "result dropped while stalled")

  // a stalled result keeps its payload
  `FRP_ASSERT_NEXT(a_out_stable, out_tvalid && !out_tready, $stable(out_tdata), "result changed while stalled")

  // render, yield and rate-update flags belong to different commands
  `FRP_ASSERT_NOW(a_flags_excl, out_tvalid, $onehot0({out_tdata[frp_pkg::OUT_OK_BIT], out_tdata[frp_pkg::OUT_SY_BIT], out_tdata[frp_pkg::OUT_UPD_BIT]}), "more than one command flag set")

  // a short yield comes only with a zero millisecond count
  `FRP_ASSERT_NOW(a_yield_zero_ms, out_tvalid && out_tdata[frp_pkg::OUT_SY_BIT], out_tdata[frp_pkg::OUT_MS_LSB +: frp_pkg::MS_W] == '0, "short yield with nonzero wait")

endmodule

bind frame_rate_pacer frp_checker u_frp_checker (.*);

>>> tb/tb_frame_rate_pacer.sv
// self-checking testbench for the frame pacer: stream stimulus, config writes, scoreboard
// depends on frp_pkg and frame_rate_pacer
`timescale 1ns / 1ps

module tb_frame_rate_pacer;
  import frp_pkg::*;

  localparam int unsigned STALL_LIMIT  = 5000;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned DRAIN_CYCLES = 200;
  localparam int unsigned PHASES       = 10;
  localparam int unsigned PHASE_ITEMS  = 73;

  // one result transaction, unpacked from out_tdata
  typedef struct packed {
    logic              render_ok;
    logic [MS_W-1:0]   wait_ms;
    logic              short_yield;
    logic              fps_updated;
    logic [RATE_W-1:0] fps_x256;
  } pacer_result_t;

  // pacing state copy, result prediction and in-order result checking
  class pacer_scoreboard;
    logic [FREQ_W-1:0] timer_freq;
    logic [FPS_W-1:0]  max_fps;
    logic [31:0]       frame_period;
    logic [63:0]       next_deadline;
    logic [63:0]       window_start;
    logic [FCNT_W-1:0] frame_count;
    logic [RATE_W-1:0] rate_value;
    pacer_result_t     awaited_results[$];
    int unsigned n_fail, n_checked, n_updates, n_holds, n_yields, n_saturated;

    function new();
      timer_freq    = FREQ_RESET;
      max_fps       = '0;
      frame_period  = '0;
      next_deadline = '0;
      window_start  = '0;
      frame_count   = '0;
      rate_value    = '0;
    endfunction

    function int unsigned pending();
      return awaited_results.size();
    endfunction

    // saturating sum at the all-ones deadline
    function logic [63:0] deadline_add(logic [63:0] a, logic [63:0] b);
      logic [64:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[64] ? '1 : s[63:0];
    endfunction

    function void update_period();
      frame_period  = (max_fps != 0) ? timer_freq / max_fps : '0;
      next_deadline = '0;
    endfunction

    // register write; a changed value rebuilds the period and drops the schedule
    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [FREQ_W-1:0] data);
      logic [FPS_W-1:0] fps;
      if (idx == REG_TIMER_FREQ) begin
        if (data != timer_freq) begin
          timer_freq = data;
          update_period();
        end
      end else begin
        fps = data[FPS_W-1:0];
        if (fps > FPS_CLAMP) fps = FPS_CLAMP;
        if (fps != max_fps) begin
          max_fps = fps;
          update_period();
        end
      end
    endfunction

    // accepted input transaction: advance the pacing state, queue the result
    function void note_command(cmd_t cmd, logic [TS_W-1:0] ts, logic vsync);
      logic [63:0]   now, rem, q, r, ms, prod, lim;
      logic [127:0]  scaled;
      bit            capping;
      pacer_result_t res;
      now     = {1'b0, ts};
      capping = !vsync && frame_period != 0;
      res     = '0;
      case (cmd)
        CMD_WAIT: begin
          if (capping && timer_freq != 0) begin
            if (next_deadline == 0) next_deadline = now;
            if (next_deadline > now) begin
              rem = next_deadline - now;
              q   = rem / timer_freq;
              r   = rem % timer_freq;
              if (q >= 66) begin
                ms = 65535;
              end else begin
                ms = q * 1000 + (r * 1000) / timer_freq;
                if (ms > 65535) ms = 65535;
              end
              res.wait_ms     = ms[MS_W-1:0];
              res.short_yield = (ms == 0);
            end
          end
        end
        CMD_RENDER: begin
          res.render_ok = !(capping && next_deadline != 0 && now < next_deadline);
        end
        CMD_PRESENT: begin
          if (frame_count != '1) frame_count++;
          // close the rate window once a full second has gone by
          if (timer_freq != 0 && now >= window_start && now - window_start >= timer_freq) begin
            prod   = {32'd0, frame_count} * {32'd0, timer_freq};
            scaled = ({64'd0, prod} << FRAC_W) / {64'd0, now - window_start};
            rate_value      = (scaled > 128'hFFFF_FFFF) ? '1 : scaled[RATE_W-1:0];
            frame_count     = '0;
            window_start    = now;
            res.fps_updated = 1'b1;
          end
          // step the deadline, resync when too far behind
          if (capping) begin
            if (next_deadline == 0) next_deadline = now;
            next_deadline = deadline_add(next_deadline, {32'd0, frame_period});
            lim = deadline_add(next_deadline, {32'd0, frame_period} * RESYNC_FRAMES);
            if (now > lim) next_deadline = deadline_add(now, {32'd0, frame_period});
          end
        end
        default: begin
          window_start = now;
          frame_count  = '0;
        end
      endcase
      res.fps_x256 = rate_value;
      if (res.fps_updated) n_updates++;
      if (cmd == CMD_RENDER && !res.render_ok) n_holds++;
      if (res.short_yield) n_yields++;
      if (res.wait_ms == '1) n_saturated++;
      awaited_results.push_back(res);
    endfunction

    // accepted result transaction against the oldest expectation
    function void check_result(logic [OUT_DATA_W-1:0] word);
      pacer_result_t want, got;
      got.render_ok   = word[OUT_OK_BIT];
      got.wait_ms     = word[OUT_MS_LSB +: MS_W];
      got.short_yield = word[OUT_SY_BIT];
      got.fps_updated = word[OUT_UPD_BIT];
      got.fps_x256    = word[OUT_RATE_LSB +: RATE_W];
      if (awaited_results.size() == 0) begin
        $error("result %h arrived with no command outstanding", word);
        n_fail++;
        return;
      end
      want = awaited_results.pop_front();
      n_checked++;
      if (got.render_ok !== want.render_ok) begin
        $error("render_ok: expected %0d, got %0d", want.render_ok, got.render_ok);
        n_fail++;
      end
      if (got.wait_ms !== want.wait_ms) begin
        $error("wait_ms: expected %0d, got %0d", want.wait_ms, got.wait_ms);
        n_fail++;
      end
      if (got.short_yield !== want.short_yield) begin
        $error("short_yield: expected %0d, got %0d", want.short_yield, got.short_yield);
        n_fail++;
      end
      if (got.fps_updated !== want.fps_updated) begin
        $error("fps_updated: expected %0d, got %0d", want.fps_updated, got.fps_updated);
        n_fail++;
      end
      if (got.fps_x256 !== want.fps_x256) begin
        $error("fps_x256: expected %0d, got %0d", want.fps_x256, got.fps_x256);
        n_fail++;
      end
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic [IN_USER_W-1:0]  in_tuser = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [FREQ_W-1:0]     cfg_data = '0;

  pacer_scoreboard sb;
  int unsigned items_sent = 0;
  int unsigned results_seen = 0;
  int unsigned n_settings = 0;
  int unsigned tx_idle_pct = 11;
  int unsigned rx_idle_pct = 85;
  int unsigned hold_req = 0;
  int unsigned hold_ack = 0;
  int unsigned hold_left = 0;
  int unsigned quiet_cycles = 0;
  logic [TS_W-1:0] t_now = '0;

  frame_rate_pacer DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // input transaction monitor feeds the prediction
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) begin
      sb.note_command(cmd_t'(in_tuser), in_tdata[TS_W-1:0], in_tdata[IN_VSYNC_BIT]);
    end
  end

  // result transaction monitor
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      sb.check_result(out_tdata);
      results_seen <= results_seen + 1;
    end
  end

  // receiver: random backpressure, plus a long hold-off on request
  always @(posedge clk) begin
    if (hold_ack != hold_req) begin
      hold_ack   <= hold_req;
      hold_left  <= HOLD_CYCLES;
      out_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left  <= hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end
  end

  // watchdog on cycles with no transaction on any channel
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == STALL_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
      $display("frame_rate_pacer regression: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_cmd(input cmd_t cmd, input logic [TS_W-1:0] ts, input logic vsync);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {vsync, ts};
    do @(posedge clk); while (!in_tready);
    items_sent++;
  endtask

  // leaves cfg_valid high so back-to-back writes need no gap
  task automatic write_reg_txn(input logic [CFG_IDX_W-1:0] idx, input logic [FREQ_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, data);
  endtask

  task automatic configure(input logic [FREQ_W-1:0] freq, input logic [FPS_W-1:0] fps);
    if ($urandom_range(0, 1)) begin
      write_reg_txn(REG_TIMER_FREQ, freq);
      write_reg_txn(REG_MAX_FPS, {22'd0, fps});
    end else begin
      write_reg_txn(REG_MAX_FPS, {22'd0, fps});
      write_reg_txn(REG_TIMER_FREQ, freq);
    end
    cfg_valid <= 1'b0;
    n_settings++;
  endtask

  // stop offering and wait for every outstanding result
  task automatic drain();
    in_tvalid <= 1'b0;
    while (results_seen < items_sent) @(posedge clk);
  endtask

  task automatic set_idling(input int unsigned tx, input int unsigned rx);
    tx_idle_pct = tx;
    rx_idle_pct <= rx;
  endtask

  // frame-to-frame time step, scaled to the current period and tick rate
  function automatic logic [63:0] pick_step();
    logic [63:0] base;
    base = (sb.frame_period != 0) ? {32'd0, sb.frame_period} :
           (sb.timer_freq != 0) ? {32'd0, sb.timer_freq / 60 + 1} : 64'd1000;
    case ($urandom_range(0, 5))
      0: pick_step = base / 2;
      1: pick_step = base;
      2: pick_step = base + $urandom_range(0, 1000);
      3: pick_step = sb.timer_freq / 4 + 1;
      4: pick_step = base * 20;
      default: pick_step = $urandom_range(0, 3);
    endcase
  endfunction

  // mostly well-formed frame loops, the rest random commands and odd timestamps
  task automatic run_items(input int unsigned n_items);
    int unsigned start;
    logic        vs;
    logic [63:0] stp, raw;
    cmd_t        c;
    start = items_sent;
    while (items_sent - start < n_items) begin
      if ($urandom_range(0, 99) < 80) begin
        vs  = ($urandom_range(0, 9) == 0);
        stp = pick_step();
        send_cmd(CMD_WAIT, t_now, vs);
        if ($urandom_range(0, 1)) send_cmd(CMD_RENDER, t_now + stp / 2, vs);
        t_now = t_now + stp;
        send_cmd(CMD_RENDER, t_now, vs);
        send_cmd(CMD_PRESENT, t_now, vs);
        if ($urandom_range(0, 19) == 0) send_cmd(CMD_RESTART, t_now, vs);
      end else begin
        c   = cmd_t'($urandom_range(0, 3));
        raw = {$urandom, $urandom};
        case ($urandom_range(0, 3))
          0: raw = {1'b0, raw[62:0]};
          1: raw = (t_now > 1000) ? t_now - $urandom_range(0, 1000) : 64'd0;
          2: raw = t_now + $urandom_range(0, 1000);
          default: raw = {2'b00, raw[61:0]};
        endcase
        send_cmd(c, raw[TS_W-1:0], 1'($urandom_range(0, 1)));
        if (c == CMD_PRESENT && !raw[62]) t_now = raw[TS_W-1:0];
      end
      if (t_now[TS_W-1]) t_now = {31'd0, $urandom};
    end
  endtask

  task automatic configure_phase(input int unsigned ph);
    logic [FREQ_W-1:0] freq;
    logic [FPS_W-1:0]  fps;
    case (ph)
      0: begin freq = 32'd1000;        fps = 10'd30;   end
      1: begin freq = 32'd1;           fps = 10'd1;    end
      2: begin freq = 32'hFFFF_FFFF;   fps = 10'd1000; end
      3: begin freq = 32'd0;           fps = 10'd60;   end
      4: begin freq = 32'd10_000_000;  fps = 10'd1023; end
      5: begin freq = 32'd50_000;      fps = 10'd0;    end
      7: begin freq = 32'd100_000;     fps = 10'd144;  end
      9: begin freq = $urandom_range(1, 5000); fps = $urandom_range(0, 1023); end
      default: begin freq = $urandom; fps = $urandom_range(0, 1023); end
    endcase
    configure(freq, fps);
  endtask

  initial begin
    sb = new();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // directed: reset registers, capping inactive
    send_cmd(CMD_RENDER, 63'd0, 1'b0);
    send_cmd(CMD_WAIT, 63'd0, 1'b0);
    send_cmd(CMD_PRESENT, 63'd0, 1'b0);
    send_cmd(CMD_RESTART, '1, 1'b0);
    // timestamp behind the window start keeps it open
    send_cmd(CMD_PRESENT, 63'd5, 1'b0);
    send_cmd(CMD_PRESENT, '1, 1'b0);
    drain();

    // directed: 10 fps at 100k ticks/s, period of 10000 ticks
    configure(32'd100_000, 10'd10);
    send_cmd(CMD_RESTART, 63'd0, 1'b0);
    // deadline taken from timestamp zero still means no schedule
    send_cmd(CMD_WAIT, 63'd0, 1'b0);
    send_cmd(CMD_RENDER, 63'd0, 1'b0);
    send_cmd(CMD_PRESENT, 63'd0, 1'b0);
    // one tick ahead gives a short yield
    send_cmd(CMD_WAIT, 63'd9999, 1'b0);
    send_cmd(CMD_RENDER, 63'd5000, 1'b0);
    send_cmd(CMD_RENDER, 63'd5000, 1'b1);
    send_cmd(CMD_WAIT, 63'd5000, 1'b1);
    send_cmd(CMD_WAIT, 63'd1000, 1'b0);
    send_cmd(CMD_RENDER, 63'd10000, 1'b0);
    // window closes, then a resync after falling behind
    send_cmd(CMD_PRESENT, 63'd100_000, 1'b0);
    send_cmd(CMD_PRESENT, 63'd300_000, 1'b0);
    send_cmd(CMD_WAIT, 63'd0, 1'b0);
    // far deadline saturates the wait
    send_cmd(CMD_PRESENT, 63'h4000_0000_0000_0000, 1'b0);
    send_cmd(CMD_WAIT, 63'd1, 1'b0);
    send_cmd(CMD_RENDER, '1, 1'b0);
    send_cmd(CMD_RESTART, 63'h4000_0000_0000_0000, 1'b1);
    send_cmd(CMD_PRESENT, 63'h4000_0000_0000_C350, 1'b0);

    // random phases, each under its own register setting
    for (int unsigned ph = 0; ph < PHASES; ph++) begin
      drain();
      configure_phase(ph);
      if (ph == 3) set_idling(85, 11);
      if (ph == 7) set_idling(0, 0);
      t_now = {31'd0, $urandom};
      if (ph == 5) begin
        // receiver holds off while the sender keeps pushing
        hold_req <= hold_req + 1;
        tx_idle_pct = 0;
        run_items(14);
        tx_idle_pct = 85;
      end
      run_items(PHASE_ITEMS);
    end

    drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.pending() != 0) $error("%0d expected results never arrived", sb.pending());
    $display("covered %0d commands over %0d register settings: %0d rate updates, %0d render holds",
             items_sent, n_settings, sb.n_updates, sb.n_holds);
    $display("%0d short yields, %0d saturated waits, %0d results checked",
             sb.n_yields, sb.n_saturated, sb.n_checked);
    if (sb.n_fail == 0 && sb.pending() == 0) begin
      $display("frame_rate_pacer regression: pass");
    end else begin
      $display("frame_rate_pacer regression: fail");
    end
    $finish;
  end

endmodule
